// ----- rtl/ates_pkg.sv -----
// Shared types, codes and constants for the terminal screen engine.
`default_nettype none

package ates_pkg;

   // Default geometry.
   localparam int DEF_SCREEN_COLS = 80;
   localparam int DEF_SCREEN_ROWS = 24;
   localparam int DEF_TAB_WIDTH   = 8;

   // Fixed field widths.
   localparam int OPCODE_W = 1;
   localparam int BYTE_W   = 8;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int CHAR_W   = 7;
   localparam int COLOR_W  = 4;
   localparam int MODE_W   = 2;
   localparam int PARAM_W  = 14;
   localparam int CELL_W   = CHAR_W + COLOR_W;

   localparam logic [OPCODE_W-1:0] OPCODE_READ = 1'b1;

   // Byte codes.
   localparam logic [BYTE_W-1:0] CHAR_BEL    = 8'h07;
   localparam logic [BYTE_W-1:0] CHAR_BS     = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_ESC    = 8'h1B;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_SEMI   = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_RBRACK = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_DEL    = 8'h7F;
   localparam logic [BYTE_W-1:0] PRINT_LO    = 8'd32;
   localparam logic [BYTE_W-1:0] PRINT_HI    = 8'd126;
   localparam logic [BYTE_W-1:0] FINAL_LO    = 8'h40;
   localparam logic [BYTE_W-1:0] FINAL_HI    = 8'h7E;

   // CSI final bytes that do something.
   localparam logic [BYTE_W-1:0] FIN_SGR = 8'h6D;  // m
   localparam logic [BYTE_W-1:0] FIN_CUP = 8'h48;  // H
   localparam logic [BYTE_W-1:0] FIN_HVP = 8'h66;  // f
   localparam logic [BYTE_W-1:0] FIN_ED  = 8'h4A;  // J
   localparam logic [BYTE_W-1:0] FIN_EL  = 8'h4B;  // K

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CHAR_QMARK = 7'h3F;

   localparam logic [COLOR_W-1:0] COLOR_WHITE = 4'd8;
   localparam logic [COLOR_W-1:0] COLOR_NONE  = 4'd0;

   localparam logic [PARAM_W-1:0] PARAM_MAX      = 14'h3FFF;
   localparam logic [PARAM_W-1:0] SGR_RESET      = 14'd0;
   localparam logic [PARAM_W-1:0] SGR_FG_LO      = 14'd30;
   localparam logic [PARAM_W-1:0] SGR_FG_HI      = 14'd37;
   localparam logic [PARAM_W-1:0] SGR_FG_DEFAULT = 14'd39;
   localparam logic [PARAM_W-1:0] ED_ALL         = 14'd2;
   localparam logic [PARAM_W-1:0] EL_TO_END      = 14'd0;
   localparam logic [PARAM_W-1:0] EL_ALL         = 14'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_CSI    = 2'd2,
      MODE_OSC    = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_LF,
      ST_SWEEP,
      ST_PUT,
      ST_TAB,
      ST_BS,
      ST_READ,
      ST_WIPE,
      ST_DONE
   } ctl_state_type;

   // Work that a decoded transaction still needs after its parser update.
   typedef enum logic [3:0] {
      ACT_DONE,
      ACT_LF,
      ACT_LF_PUT,
      ACT_PUT,
      ACT_TAB,
      ACT_BS,
      ACT_SWEEP,
      ACT_WIPE,
      ACT_READ
   } act_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic lf;
      logic sweep;
      logic put;
      logic tab;
      logic bs;
      logic read;
      logic wipe;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    lf_scroll;
      logic    sweep_last;
      logic    tab_last;
      logic    wipe_last;
      logic    out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/ates_if.sv -----
// Request and response channel interfaces of the terminal screen engine.
`default_nettype none

interface ates_req_if;
   logic                           valid;
   logic                           ready;
   logic [ates_pkg::OPCODE_W-1:0]  opcode;
   logic [ates_pkg::BYTE_W-1:0]    stream_byte;
   logic [ates_pkg::ROW_W-1:0]     read_row;
   logic [ates_pkg::COL_W-1:0]     read_col;

   modport source (output valid, output opcode, output stream_byte, output read_row,
                   output read_col, input ready);
   modport sink (input valid, input opcode, input stream_byte, input read_row,
                 input read_col, output ready);
endinterface

interface ates_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ates_pkg::CHAR_W-1:0]   cell_char;
   logic [ates_pkg::COLOR_W-1:0]  cell_color;
   logic [ates_pkg::ROW_W-1:0]    cursor_row;
   logic [ates_pkg::COL_W-1:0]    cursor_col;
   logic [ates_pkg::MODE_W-1:0]   parser_mode;

   modport source (output valid, output cell_char, output cell_color, output cursor_row,
                   output cursor_col, output parser_mode, input ready);
   modport sink (input valid, input cell_char, input cell_color, input cursor_row,
                 input cursor_col, input parser_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/ates_ram.sv -----
// Generic single-clock RAM with one write port and a registered read port.
`default_nettype none

module ates_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/ates_ctrl.sv -----
// Sequencer that steps one transaction through decode, cell writes and reply.
`default_nettype none

module ates_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire ates_pkg::status_type status,
   output      ates_pkg::cmd_type    cmd
);

   ates_pkg::ctl_state_type state_ff, state_in;
   logic                    put_after_ff, put_after_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ates_pkg::ST_INIT;
         put_after_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         put_after_ff <= put_after_in;
      end
   end

   // Next state.
   always_comb begin
      state_in     = state_ff;
      put_after_in = put_after_ff;
      unique case (state_ff)
         ates_pkg::ST_INIT: begin
            if (status.wipe_last) state_in = ates_pkg::ST_IDLE;
         end
         ates_pkg::ST_IDLE: begin
            if (req_valid) state_in = ates_pkg::ST_DECODE;
         end
         ates_pkg::ST_DECODE: begin
            put_after_in = (status.act == ates_pkg::ACT_LF_PUT);
            unique case (status.act)
               ates_pkg::ACT_LF,
               ates_pkg::ACT_LF_PUT: state_in = ates_pkg::ST_LF;
               ates_pkg::ACT_PUT:    state_in = ates_pkg::ST_PUT;
               ates_pkg::ACT_TAB:    state_in = ates_pkg::ST_TAB;
               ates_pkg::ACT_BS:     state_in = ates_pkg::ST_BS;
               ates_pkg::ACT_SWEEP:  state_in = ates_pkg::ST_SWEEP;
               ates_pkg::ACT_WIPE:   state_in = ates_pkg::ST_WIPE;
               ates_pkg::ACT_READ:   state_in = ates_pkg::ST_READ;
               default:              state_in = ates_pkg::ST_DONE;
            endcase
         end
         ates_pkg::ST_LF: begin
            if (status.lf_scroll)  state_in = ates_pkg::ST_SWEEP;
            else if (put_after_ff) state_in = ates_pkg::ST_PUT;
            else                   state_in = ates_pkg::ST_DONE;
         end
         ates_pkg::ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = put_after_ff ? ates_pkg::ST_PUT : ates_pkg::ST_DONE;
            end
         end
         ates_pkg::ST_PUT:  state_in = ates_pkg::ST_DONE;
         ates_pkg::ST_TAB: begin
            if (status.tab_last) state_in = ates_pkg::ST_DONE;
         end
         ates_pkg::ST_BS:   state_in = ates_pkg::ST_DONE;
         ates_pkg::ST_READ: state_in = ates_pkg::ST_DONE;
         ates_pkg::ST_WIPE: begin
            if (status.wipe_last) state_in = ates_pkg::ST_DONE;
         end
         ates_pkg::ST_DONE: begin
            if (status.out_free) state_in = ates_pkg::ST_IDLE;
         end
         default: state_in = ates_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ates_pkg::ST_INIT:   cmd.wipe = 1'b1;
         ates_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ates_pkg::ST_DECODE: cmd.decode   = 1'b1;
         ates_pkg::ST_LF:     cmd.lf       = 1'b1;
         ates_pkg::ST_SWEEP:  cmd.sweep    = 1'b1;
         ates_pkg::ST_PUT:    cmd.put      = 1'b1;
         ates_pkg::ST_TAB:    cmd.tab      = 1'b1;
         ates_pkg::ST_BS:     cmd.bs       = 1'b1;
         ates_pkg::ST_READ:   cmd.read     = 1'b1;
         ates_pkg::ST_WIPE:   cmd.wipe     = 1'b1;
         ates_pkg::ST_DONE:   cmd.out_load = status.out_free;
         default:             cmd          = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/ates_datapath.sv -----
// Parser registers, cursor, screen memory and the response register.
`default_nettype none

module ates_datapath #(
   parameter int SCREEN_COLS = ates_pkg::DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS = ates_pkg::DEF_SCREEN_ROWS,
   parameter int TAB_WIDTH   = ates_pkg::DEF_TAB_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ates_pkg::cmd_type               cmd,
   output      ates_pkg::status_type            status,
   input  wire logic [ates_pkg::OPCODE_W-1:0]   req_opcode,
   input  wire logic [ates_pkg::BYTE_W-1:0]     req_stream_byte,
   input  wire logic [ates_pkg::ROW_W-1:0]      req_read_row,
   input  wire logic [ates_pkg::COL_W-1:0]      req_read_col,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [ates_pkg::CHAR_W-1:0]     rsp_cell_char,
   output      logic [ates_pkg::COLOR_W-1:0]    rsp_cell_color,
   output      logic [ates_pkg::ROW_W-1:0]      rsp_cursor_row,
   output      logic [ates_pkg::COL_W-1:0]      rsp_cursor_col,
   output      logic [ates_pkg::MODE_W-1:0]     rsp_parser_mode
);

   localparam int RowW  = $clog2(SCREEN_ROWS);
   localparam int SumW  = RowW + 1;
   localparam int ColW  = $clog2(SCREEN_COLS + 1);
   localparam int Cells = SCREEN_ROWS * SCREEN_COLS;
   localparam int AddrW = $clog2(Cells);
   localparam int TabN  = 2 ** ColW;
   localparam int AccW  = ates_pkg::PARAM_W + 4;

   // Tab stop lookup: entry c is set when c + 1 is a tab stop.
   logic [TabN-1:0] tab_stop;
   for (genvar i = 0; i < TabN; i++) begin : g_tab
      localparam bit Stop = ((i + 1) % TAB_WIDTH) == 0;
      assign tab_stop[i] = Stop;
   end

   // Latched transaction.
   logic [ates_pkg::OPCODE_W-1:0] opcode_ff, opcode_in;
   logic [ates_pkg::BYTE_W-1:0]   byte_ff, byte_in;
   logic [ates_pkg::ROW_W-1:0]    rd_row_ff, rd_row_in;
   logic [ates_pkg::COL_W-1:0]    rd_col_ff, rd_col_in;

   // Terminal state.
   logic [RowW-1:0]                top_ff, top_in;
   logic [RowW-1:0]                row_ff, row_in;
   logic [ColW-1:0]                col_ff, col_in;
   logic [ates_pkg::COLOR_W-1:0]   color_ff, color_in;
   ates_pkg::mode_type             mode_ff, mode_in;
   logic [ates_pkg::PARAM_W-1:0]   accum_ff, accum_in;
   logic                           has_ff, has_in;
   logic [1:0]                     count_ff, count_in;
   logic [ates_pkg::PARAM_W-1:0]   first_ff, first_in;
   logic [ates_pkg::PARAM_W-1:0]   second_ff, second_in;
   logic [ates_pkg::COLOR_W-1:0]   pcolor_ff, pcolor_in;
   logic                           pvalid_ff, pvalid_in;

   // Sweep and clear counters.
   logic [RowW-1:0]                sweep_row_ff, sweep_row_in;
   logic [ColW-1:0]                sweep_col_ff, sweep_col_in;
   logic [ates_pkg::COLOR_W-1:0]   sweep_color_ff, sweep_color_in;
   logic [AddrW-1:0]               wipe_cnt_ff, wipe_cnt_in;

   // Response register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ates_pkg::CHAR_W-1:0]    out_char_ff, out_char_in;
   logic [ates_pkg::COLOR_W-1:0]   out_color_ff, out_color_in;
   logic [ates_pkg::ROW_W-1:0]     out_row_ff, out_row_in;
   logic [ates_pkg::COL_W-1:0]     out_col_ff, out_col_in;
   logic [ates_pkg::MODE_W-1:0]    out_mode_ff, out_mode_in;

   // Byte classification and parameter arithmetic.
   logic                           is_digit, is_final, is_read, pending, in_range;
   logic [AccW-1:0]                acc_prod;
   logic [ates_pkg::PARAM_W-1:0]   acc_sat, v, first_n, second_n, row_v, col_p, col_v;
   logic [1:0]                     count_n;
   logic [ates_pkg::COLOR_W-1:0]   pcolor_n;
   logic                           pvalid_n;
   logic [RowW-1:0]                row_cl;
   logic [ColW-1:0]                col_cl;
   logic [ates_pkg::CHAR_W-1:0]    print_char;

   always_comb begin
      is_digit = (byte_ff >= ates_pkg::CHAR_ZERO) && (byte_ff <= ates_pkg::CHAR_NINE);
      is_final = (byte_ff >= ates_pkg::FINAL_LO) && (byte_ff <= ates_pkg::FINAL_HI);
      is_read  = (opcode_ff == ates_pkg::OPCODE_READ);
      pending  = (col_ff >= ColW'(SCREEN_COLS));
      in_range = (32'(rd_row_ff) < SCREEN_ROWS) && (32'(rd_col_ff) < SCREEN_COLS);

      acc_prod = AccW'(accum_ff) * AccW'(10) + AccW'(byte_ff[3:0]);
      acc_sat  = (acc_prod > AccW'(ates_pkg::PARAM_MAX)) ? ates_pkg::PARAM_MAX
                                                         : acc_prod[ates_pkg::PARAM_W-1:0];

      // Closing the current parameter.
      v        = has_ff ? accum_ff : '0;
      first_n  = (count_ff == 2'd0) ? v : first_ff;
      second_n = (count_ff == 2'd1) ? v : second_ff;
      count_n  = (count_ff < 2'd3) ? count_ff + 2'd1 : count_ff;
      pcolor_n = pcolor_ff;
      pvalid_n = pvalid_ff;
      if ((v == ates_pkg::SGR_RESET) || (v == ates_pkg::SGR_FG_DEFAULT)) begin
         pcolor_n = ates_pkg::COLOR_WHITE;
         pvalid_n = 1'b1;
      end else if ((v >= ates_pkg::SGR_FG_LO) && (v <= ates_pkg::SGR_FG_HI)) begin
         pcolor_n = ates_pkg::COLOR_W'(v - ates_pkg::SGR_FG_LO);
         pvalid_n = 1'b1;
      end

      // Cursor position parameters are one-based and clamped.
      row_v  = (first_n == '0) ? '0 : first_n - 1'b1;
      row_cl = (row_v > ates_pkg::PARAM_W'(SCREEN_ROWS - 1)) ? RowW'(SCREEN_ROWS - 1)
                                                              : RowW'(row_v);
      col_p  = (count_n >= 2'd2) ? second_n : '0;
      col_v  = (col_p == '0) ? '0 : col_p - 1'b1;
      col_cl = (col_v > ates_pkg::PARAM_W'(SCREEN_COLS - 1)) ? ColW'(SCREEN_COLS - 1)
                                                              : ColW'(col_v);

      print_char = ((byte_ff < ates_pkg::PRINT_LO) || (byte_ff > ates_pkg::PRINT_HI))
                   ? ates_pkg::CHAR_QMARK : byte_ff[ates_pkg::CHAR_W-1:0];
   end

   // What the transaction needs after its decode cycle.
   ates_pkg::act_type act;

   always_comb begin
      act = ates_pkg::ACT_DONE;
      if (is_read) begin
         act = ates_pkg::ACT_READ;
      end else if (mode_ff == ates_pkg::MODE_NORMAL) begin
         unique case (byte_ff)
            ates_pkg::CHAR_ESC,
            ates_pkg::CHAR_CR:  act = ates_pkg::ACT_DONE;
            ates_pkg::CHAR_LF:  act = ates_pkg::ACT_LF;
            ates_pkg::CHAR_TAB: act = pending ? ates_pkg::ACT_DONE : ates_pkg::ACT_TAB;
            ates_pkg::CHAR_BS,
            ates_pkg::CHAR_DEL: act = (col_ff != '0) ? ates_pkg::ACT_BS : ates_pkg::ACT_DONE;
            default:            act = pending ? ates_pkg::ACT_LF_PUT : ates_pkg::ACT_PUT;
         endcase
      end else if ((mode_ff == ates_pkg::MODE_CSI) && !is_digit &&
                   (byte_ff != ates_pkg::CHAR_SEMI) && is_final) begin
         if ((byte_ff == ates_pkg::FIN_ED) && (first_n == ates_pkg::ED_ALL)) begin
            act = ates_pkg::ACT_WIPE;
         end else if (byte_ff == ates_pkg::FIN_EL) begin
            if ((first_n == ates_pkg::EL_TO_END) && !pending) act = ates_pkg::ACT_SWEEP;
            else if (first_n == ates_pkg::EL_ALL)             act = ates_pkg::ACT_SWEEP;
         end
      end
   end

   // Screen memory addressing through the row ring.
   logic [RowW-1:0]             a_row, prow;
   logic [ColW-1:0]             a_col;
   logic [SumW-1:0]             psum;
   logic [AddrW-1:0]            cell_addr, ram_addr;
   logic                        ram_we, ram_re;
   logic [ates_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

   always_comb begin
      a_row = row_ff;
      a_col = col_ff;
      if (cmd.sweep) begin
         a_row = sweep_row_ff;
         a_col = sweep_col_ff;
      end else if (cmd.bs) begin
         a_col = col_ff - 1'b1;
      end else if (cmd.read) begin
         a_row = RowW'(rd_row_ff);
         a_col = ColW'(rd_col_ff);
      end
      psum      = SumW'(top_ff) + SumW'(a_row);
      prow      = (psum >= SumW'(SCREEN_ROWS)) ? RowW'(psum - SumW'(SCREEN_ROWS)) : RowW'(psum);
      cell_addr = AddrW'(prow) * AddrW'(SCREEN_COLS) + AddrW'(a_col);

      ram_we   = cmd.wipe | cmd.sweep | cmd.put | cmd.tab | cmd.bs;
      ram_re   = cmd.read & in_range;
      ram_addr = cmd.wipe ? wipe_cnt_ff : cell_addr;
      if (cmd.wipe)      ram_wdata = {ates_pkg::CHAR_SPACE, ates_pkg::COLOR_WHITE};
      else if (cmd.sweep) ram_wdata = {ates_pkg::CHAR_SPACE, sweep_color_ff};
      else if (cmd.put)  ram_wdata = {print_char, color_ff};
      else               ram_wdata = {ates_pkg::CHAR_SPACE, color_ff};
   end

   ates_ram #(
      .WIDTH (ates_pkg::CELL_W),
      .DEPTH (Cells)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   // Next values.
   always_comb begin
      opcode_in      = opcode_ff;
      byte_in        = byte_ff;
      rd_row_in      = rd_row_ff;
      rd_col_in      = rd_col_ff;
      top_in         = top_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      color_in       = color_ff;
      mode_in        = mode_ff;
      accum_in       = accum_ff;
      has_in         = has_ff;
      count_in       = count_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      pcolor_in      = pcolor_ff;
      pvalid_in      = pvalid_ff;
      sweep_row_in   = sweep_row_ff;
      sweep_col_in   = sweep_col_ff;
      sweep_color_in = sweep_color_ff;
      wipe_cnt_in    = wipe_cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_char_in    = out_char_ff;
      out_color_in   = out_color_ff;
      out_row_in     = out_row_ff;
      out_col_in     = out_col_ff;
      out_mode_in    = out_mode_ff;

      if (cmd.load) begin
         opcode_in = req_opcode;
         byte_in   = req_stream_byte;
         rd_row_in = req_read_row;
         rd_col_in = req_read_col;
      end

      if (cmd.decode && !is_read) begin
         unique case (mode_ff)
            ates_pkg::MODE_NORMAL: begin
               if (byte_ff == ates_pkg::CHAR_ESC) mode_in = ates_pkg::MODE_ESC;
            end
            ates_pkg::MODE_ESC: begin
               if (byte_ff == ates_pkg::CHAR_LBRACK) begin
                  accum_in  = '0;
                  has_in    = 1'b0;
                  count_in  = '0;
                  first_in  = '0;
                  second_in = '0;
                  pcolor_in = ates_pkg::COLOR_WHITE;
                  pvalid_in = 1'b0;
                  mode_in   = ates_pkg::MODE_CSI;
               end else if (byte_ff == ates_pkg::CHAR_RBRACK) begin
                  mode_in = ates_pkg::MODE_OSC;
               end else begin
                  mode_in = ates_pkg::MODE_NORMAL;
               end
            end
            ates_pkg::MODE_CSI: begin
               if (is_digit) begin
                  accum_in = acc_sat;
                  has_in   = 1'b1;
               end else if ((byte_ff == ates_pkg::CHAR_SEMI) || is_final) begin
                  first_in  = first_n;
                  second_in = second_n;
                  count_in  = count_n;
                  pcolor_in = pcolor_n;
                  pvalid_in = pvalid_n;
                  accum_in  = '0;
                  has_in    = 1'b0;
                  if (is_final) begin
                     mode_in = ates_pkg::MODE_NORMAL;
                     if (byte_ff == ates_pkg::FIN_SGR) begin
                        if (pvalid_n) color_in = pcolor_n;
                     end else if ((byte_ff == ates_pkg::FIN_CUP) ||
                                  (byte_ff == ates_pkg::FIN_HVP)) begin
                        row_in = row_cl;
                        col_in = col_cl;
                     end else if (act == ates_pkg::ACT_WIPE) begin
                        top_in = '0;
                        row_in = '0;
                        col_in = '0;
                     end else if (act == ates_pkg::ACT_SWEEP) begin
                        sweep_row_in   = row_ff;
                        sweep_col_in   = (first_n == ates_pkg::EL_ALL) ? '0 : col_ff;
                        sweep_color_in = color_ff;
                     end
                  end
               end else begin
                  accum_in = '0;
                  has_in   = 1'b0;
               end
            end
            ates_pkg::MODE_OSC: begin
               if ((byte_ff == ates_pkg::CHAR_BEL) || (byte_ff == ates_pkg::CHAR_BSLASH)) begin
                  mode_in = ates_pkg::MODE_NORMAL;
               end
            end
            default: mode_in = ates_pkg::MODE_NORMAL;
         endcase
      end

      if (cmd.lf) begin
         col_in = '0;
         if ((32'(row_ff) + 1) < SCREEN_ROWS) begin
            row_in = row_ff + 1'b1;
         end else begin
            // Scroll: rotate the ring and blank the new bottom row.
            top_in         = (top_ff == RowW'(SCREEN_ROWS - 1)) ? '0 : top_ff + 1'b1;
            row_in         = RowW'(SCREEN_ROWS - 1);
            sweep_row_in   = RowW'(SCREEN_ROWS - 1);
            sweep_col_in   = '0;
            sweep_color_in = ates_pkg::COLOR_WHITE;
         end
      end
      if (cmd.sweep)          sweep_col_in = sweep_col_ff + 1'b1;
      if (cmd.put || cmd.tab) col_in = col_ff + 1'b1;
      if (cmd.bs)             col_in = col_ff - 1'b1;
      if (cmd.wipe) begin
         wipe_cnt_in = (wipe_cnt_ff == AddrW'(Cells - 1)) ? '0 : wipe_cnt_ff + 1'b1;
      end

      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         out_char_in  = (is_read && in_range) ? ram_rdata[ates_pkg::CELL_W-1:ates_pkg::COLOR_W]
                                              : '0;
         if (is_read) begin
            out_color_in = in_range ? ram_rdata[ates_pkg::COLOR_W-1:0] : ates_pkg::COLOR_NONE;
         end else begin
            out_color_in = color_ff;
         end
         out_row_in  = ates_pkg::ROW_W'(row_ff);
         out_col_in  = ates_pkg::COL_W'(col_ff);
         out_mode_in = mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         color_ff     <= ates_pkg::COLOR_WHITE;
         mode_ff      <= ates_pkg::MODE_NORMAL;
         accum_ff     <= '0;
         has_ff       <= 1'b0;
         count_ff     <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         pcolor_ff    <= ates_pkg::COLOR_WHITE;
         pvalid_ff    <= 1'b0;
         wipe_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff       <= top_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         color_ff     <= color_in;
         mode_ff      <= mode_in;
         accum_ff     <= accum_in;
         has_ff       <= has_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         pcolor_ff    <= pcolor_in;
         pvalid_ff    <= pvalid_in;
         wipe_cnt_ff  <= wipe_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff      <= opcode_in;
      byte_ff        <= byte_in;
      rd_row_ff      <= rd_row_in;
      rd_col_ff      <= rd_col_in;
      sweep_row_ff   <= sweep_row_in;
      sweep_col_ff   <= sweep_col_in;
      sweep_color_ff <= sweep_color_in;
      out_char_ff    <= out_char_in;
      out_color_ff   <= out_color_in;
      out_row_ff     <= out_row_in;
      out_col_ff     <= out_col_in;
      out_mode_ff    <= out_mode_in;
   end

   always_comb begin
      status.act        = act;
      status.lf_scroll  = !((32'(row_ff) + 1) < SCREEN_ROWS);
      status.sweep_last = (sweep_col_ff == ColW'(SCREEN_COLS - 1));
      status.tab_last   = tab_stop[col_ff] || (col_ff == ColW'(SCREEN_COLS - 1));
      status.wipe_last  = (wipe_cnt_ff == AddrW'(Cells - 1));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_char   = out_char_ff;
   assign rsp_cell_color  = out_color_ff;
   assign rsp_cursor_row  = out_row_ff;
   assign rsp_cursor_col  = out_col_ff;
   assign rsp_parser_mode = out_mode_ff;

endmodule

`default_nettype wire

// ----- rtl/ansi_terminal_screen_engine_core.sv -----
// Top level of the ANSI terminal screen engine: sequencer plus datapath.
`default_nettype none

// Channel   Dir  Transaction payload
// --------  ---  ----------------------------------------------------------
// req_port  in   opcode, stream_byte, read_row, read_col
// rsp_port  out  cell_char, cell_color, cursor_row, cursor_col, parser_mode
//
// Each transaction is handled alone. A plain byte or a cell read passes
// through accept, decode, one screen memory access, and the response.
// Extra cells are written one at a time on the single memory write port:
// a tab writes up to TAB_WIDTH cells, a scroll or line erase walks up to
// SCREEN_COLS cells, and clearing the screen walks all SCREEN_ROWS *
// SCREEN_COLS cells. After reset the same clearing pass runs once before
// the first request is taken. A finished response waits in its own
// register, so a new request is accepted while the previous response is
// still stalled; the sequencer only holds in its reply state when a second
// response is ready before the first has been taken.

module ansi_terminal_screen_engine_core #(
   parameter int SCREEN_COLS = ates_pkg::DEF_SCREEN_COLS,
   parameter int SCREEN_ROWS = ates_pkg::DEF_SCREEN_ROWS,
   parameter int TAB_WIDTH   = ates_pkg::DEF_TAB_WIDTH
) (
   input wire logic    clock,
   input wire logic    reset,
   ates_req_if.sink    req_port,
   ates_rsp_if.source  rsp_port
);

   // Command and status groups between the sequencer and the datapath.
   ates_pkg::cmd_type    cmd;
   ates_pkg::status_type status;

   // The sequencer owns request ready and steps every transaction.
   ates_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the parser, cursor, row ring and screen memory.
   ates_datapath #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS),
      .TAB_WIDTH   (TAB_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_port.opcode),
      .req_stream_byte (req_port.stream_byte),
      .req_read_row    (req_port.read_row),
      .req_read_col    (req_port.read_col),
      .rsp_valid       (rsp_port.valid),
      .rsp_ready       (rsp_port.ready),
      .rsp_cell_char   (rsp_port.cell_char),
      .rsp_cell_color  (rsp_port.cell_color),
      .rsp_cursor_row  (rsp_port.cursor_row),
      .rsp_cursor_col  (rsp_port.cursor_col),
      .rsp_parser_mode (rsp_port.parser_mode)
   );

   // Only one kind of memory access may be commanded in a cycle.
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wipe, cmd.sweep, cmd.put, cmd.tab, cmd.bs, cmd.read}))
      else $error("more than one screen memory access commanded");

   // A response is only loaded when the response register can take it.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("response register overwritten");

   // An accepted request is decoded in the next cycle and blocks new requests.
   a_decode_follows: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> (cmd.decode && !req_port.ready))
      else $error("accepted request not decoded next cycle");

endmodule

`default_nettype wire
